// ===== rtl/tsr_pkg.sv =====
// Shared constants, codes and controller/datapath signal groups for the reassembler.
package tsr_pkg;

	localparam int CAPACITY_DEF = 1024;

	localparam int IDX_W = 32;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 3;
	localparam int CNT_W = 11;

	localparam logic REQ_SEG = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [STAT_W-1:0] ST_STORED = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP = 3'd1;
	localparam logic [STAT_W-1:0] ST_BEYOND = 3'd2;
	localparam logic [STAT_W-1:0] ST_READ_OK = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic clr;
		logic load;
		logic eval;
		logic rd_take;
		logic mk_rd_head;
		logic store;
		logic scan_take;
		logic eof_chk;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic can_read;
		logic to_store;
		logic mark_set;
		logic at_head;
		logic run_more;
	} stat_t;

endpackage

// ===== rtl/tsr_if.sv =====
// Valid/ready channel interfaces for segment/read requests and results.
interface tsr_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [tsr_pkg::IDX_W-1:0] byte_index;
	logic [tsr_pkg::BYTE_W-1:0] data_byte;
	logic has_byte;
	logic seg_first;
	logic seg_last;
	logic eof;
	modport source (output valid, req_type, byte_index, data_byte, has_byte, seg_first,
		seg_last, eof, input ready);
	modport sink (input valid, req_type, byte_index, data_byte, has_byte, seg_first,
		seg_last, eof, output ready);
endinterface

interface tsr_out_if;
	logic valid;
	logic ready;
	logic [tsr_pkg::STAT_W-1:0] status;
	logic [tsr_pkg::BYTE_W-1:0] read_byte;
	logic [tsr_pkg::CNT_W-1:0] unassembled_count;
	logic [tsr_pkg::CNT_W-1:0] readable_count;
	logic input_ended;
	modport source (output valid, status, read_byte, unassembled_count, readable_count,
		input_ended, input ready);
	modport sink (input valid, status, read_byte, unassembled_count, readable_count,
		input_ended, output ready);
endinterface

// ===== rtl/tsr_ctrl.sv =====
// Sequencing state machine for the reassembler.
module tsr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  tsr_pkg::stat_t st,
	output tsr_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_EVAL = 4'd2;
	localparam logic [3:0] S_RDFIN = 4'd3;
	localparam logic [3:0] S_MKRD = 4'd4;
	localparam logic [3:0] S_MKCHK = 4'd5;
	localparam logic [3:0] S_SCANRD = 4'd6;
	localparam logic [3:0] S_SCANCHK = 4'd7;
	localparam logic [3:0] S_EOFCHK = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = 1'b1;
				if (in_valid) state_n = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (st.is_read) begin
					state_n = st.can_read ? S_RDFIN : S_OUT;
				end else begin
					state_n = st.to_store ? S_MKRD : S_EOFCHK;
				end
			end
			S_RDFIN: begin
				cmd.rd_take = 1'b1;
				state_n = S_OUT;
			end
			S_MKRD: begin
				state_n = S_MKCHK;
			end
			S_MKCHK: begin
				cmd.store = 1'b1;
				if (!st.mark_set && st.at_head) state_n = S_SCANRD;
				else state_n = S_EOFCHK;
			end
			S_SCANRD: begin
				cmd.mk_rd_head = 1'b1;
				state_n = S_SCANCHK;
			end
			S_SCANCHK: begin
				if (st.run_more) begin
					cmd.scan_take = 1'b1;
					state_n = S_SCANRD;
				end else begin
					state_n = S_EOFCHK;
				end
			end
			S_EOFCHK: begin
				cmd.eof_chk = 1'b1;
				state_n = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_n = S_IDLE;
			end
			default: begin
				state_n = S_CLR;
			end
		endcase
	end

endmodule

// ===== rtl/tsr_dp.sv =====
// Datapath: byte ring, valid-mark memory, stream pointers and result fields.
module tsr_dp #(
	parameter int CAPACITY = tsr_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsr_pkg::cmd_t                 cmd,
	output tsr_pkg::stat_t                st,
	input  logic                          req_type,
	input  logic [tsr_pkg::IDX_W-1:0]     byte_index,
	input  logic [tsr_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          has_byte,
	input  logic                          seg_first,
	input  logic                          seg_last,
	input  logic                          eof,
	output logic [tsr_pkg::STAT_W-1:0]    status,
	output logic [tsr_pkg::BYTE_W-1:0]    read_byte,
	output logic [tsr_pkg::CNT_W-1:0]     unassembled_count,
	output logic [tsr_pkg::CNT_W-1:0]     readable_count,
	output logic                          input_ended
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int IW = tsr_pkg::IDX_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	logic [tsr_pkg::BYTE_W-1:0] byte_mem [CAPACITY];
	logic                       mark_mem [CAPACITY];

	logic                       req_q, has_q, first_q, last_q, eof_q;
	logic [IW-1:0]              idx_q;
	logic [tsr_pkg::BYTE_W-1:0] data_q;

	logic [IW-1:0]              read_q, asm_q, snap0_q, snap1_q;
	logic [AW-1:0]              read_slot_q, asm_slot_q, slot_q, clr_addr_q;
	logic [PW-1:0]              pend_q;
	logic                       eof_seen_q, ended_q, kept_q, at_head_q;
	logic [tsr_pkg::STAT_W-1:0] status_q;
	logic [tsr_pkg::BYTE_W-1:0] rbyte_q;
	logic [tsr_pkg::BYTE_W-1:0] byte_rd_q;
	logic                       mark_rd_q;

	logic [IW-1:0]  snap0_n, snap1_n, off;
	logic [IW:0]    win_end;
	logic           beyond, below, kept_hit;
	logic [AW:0]    slot_sum;
	logic [AW-1:0]  slot_n, mk_raddr, mk_waddr;
	logic           mk_we, mk_wdata, by_we, eof_n;

	always_comb begin
		snap0_n = first_q ? read_q : snap0_q;
		snap1_n = first_q ? asm_q : snap1_q;
		win_end = {1'b0, snap0_n} + (IW + 1)'(CAPACITY);
		beyond = ({1'b0, idx_q} >= win_end) || (&idx_q);
		below = idx_q < asm_q;
		kept_hit = !beyond && (idx_q >= snap1_n);
		off = idx_q - asm_q;
		slot_sum = {1'b0, asm_slot_q} + {1'b0, off[AW-1:0]};
		if (slot_sum >= (AW + 1)'(CAPACITY)) slot_sum = slot_sum - (AW + 1)'(CAPACITY);
		slot_n = slot_sum[AW-1:0];
	end

	always_comb begin
		st.clr_last = clr_addr_q == LAST_SLOT;
		st.is_read = req_q == tsr_pkg::REQ_READ;
		st.can_read = asm_q != read_q;
		st.to_store = has_q && !below && !beyond;
		st.mark_set = mark_rd_q;
		st.at_head = at_head_q;
		st.run_more = mark_rd_q && !(&asm_q);
	end

	always_comb begin
		mk_raddr = cmd.mk_rd_head ? asm_slot_q : slot_q;
		mk_we = 1'b0;
		mk_waddr = slot_q;
		mk_wdata = 1'b0;
		by_we = cmd.store && !mark_rd_q;
		if (cmd.clr) begin
			mk_we = 1'b1;
			mk_waddr = clr_addr_q;
		end else if (cmd.store && !mark_rd_q && !at_head_q) begin
			mk_we = 1'b1;
			mk_wdata = 1'b1;
		end else if (cmd.scan_take) begin
			mk_we = 1'b1;
			mk_waddr = asm_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mk_we) mark_mem[mk_waddr] <= mk_wdata;
		mark_rd_q <= mark_mem[mk_raddr];
		if (by_we) byte_mem[slot_q] <= data_q;
		byte_rd_q <= byte_mem[read_slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= byte_index;
			data_q <= data_byte;
			has_q <= has_byte;
			first_q <= seg_first;
			last_q <= seg_last;
			eof_q <= eof;
		end
		if (cmd.eval) begin
			slot_q <= slot_n;
			at_head_q <= idx_q == asm_q;
		end
	end

	assign eof_n = eof_seen_q || eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q <= '0;
			asm_q <= '0;
			snap0_q <= '0;
			snap1_q <= '0;
			read_slot_q <= '0;
			asm_slot_q <= '0;
			clr_addr_q <= '0;
			pend_q <= '0;
			eof_seen_q <= 1'b0;
			ended_q <= 1'b0;
			kept_q <= 1'b0;
			status_q <= tsr_pkg::ST_STORED;
			rbyte_q <= '0;
		end else begin
			if (cmd.clr && clr_addr_q != LAST_SLOT) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.eval) begin
				rbyte_q <= '0;
				if (req_q == tsr_pkg::REQ_READ) begin
					status_q <= st.can_read ? tsr_pkg::ST_READ_OK : tsr_pkg::ST_EMPTY;
				end else begin
					snap0_q <= snap0_n;
					snap1_q <= snap1_n;
					kept_q <= (first_q ? 1'b0 : kept_q) | kept_hit;
					if (below) status_q <= tsr_pkg::ST_DUP;
					else if (beyond) status_q <= tsr_pkg::ST_BEYOND;
					else status_q <= tsr_pkg::ST_STORED;
				end
			end
			if (cmd.rd_take) begin
				rbyte_q <= byte_rd_q;
				read_q <= read_q + 1'b1;
				read_slot_q <= (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + 1'b1;
			end
			if (cmd.store) begin
				if (mark_rd_q) begin
					status_q <= tsr_pkg::ST_DUP;
				end else if (at_head_q) begin
					asm_q <= asm_q + 1'b1;
					asm_slot_q <= (asm_slot_q == LAST_SLOT) ? '0 : asm_slot_q + 1'b1;
				end else begin
					pend_q <= pend_q + 1'b1;
				end
			end
			if (cmd.scan_take) begin
				if (pend_q != '0) pend_q <= pend_q - 1'b1;
				asm_q <= asm_q + 1'b1;
				asm_slot_q <= (asm_slot_q == LAST_SLOT) ? '0 : asm_slot_q + 1'b1;
			end
			if (cmd.eof_chk && last_q && kept_q) begin
				eof_seen_q <= eof_n;
				if (eof_n && pend_q == '0) ended_q <= 1'b1;
			end
		end
	end

	assign status = status_q;
	assign read_byte = rbyte_q;
	assign unassembled_count = tsr_pkg::CNT_W'(pend_q);
	assign readable_count = asm_q[tsr_pkg::CNT_W-1:0] - read_q[tsr_pkg::CNT_W-1:0];
	assign input_ended = ended_q;

endmodule

// ===== rtl/tcp_stream_reassembler.sv =====
// Top level of the byte-stream reassembler.
//  channel  | dir | contents
//  seg_in   | in  | segment byte or read request, stream index, flags
//  res_out  | out | status, popped byte, counts, end-of-input flag
// A read passes through an evaluate step, plus a take step when a byte is popped; a
// segment byte through evaluate, mark read and mark check, plus a read/check pair per byte
// the assembled run advances, set by the registered read of the valid-mark memory.
// After reset the whole mark memory is swept clear before seg_in is ready.
// One item is worked at a time; seg_in is ready again once res_out's transfer is done.
module tcp_stream_reassembler #(
	parameter int CAPACITY = tsr_pkg::CAPACITY_DEF
) (
	input logic      clk,
	input logic      arst_n,
	tsr_in_if.sink   seg_in,
	tsr_out_if.source res_out
);

	tsr_pkg::cmd_t  cmd;
	tsr_pkg::stat_t st;

	tsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_in.valid),
		.in_ready  (seg_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.st        (st),
		.cmd       (cmd)
	);

	tsr_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.req_type          (seg_in.req_type),
		.byte_index        (seg_in.byte_index),
		.data_byte         (seg_in.data_byte),
		.has_byte          (seg_in.has_byte),
		.seg_first         (seg_in.seg_first),
		.seg_last          (seg_in.seg_last),
		.eof               (seg_in.eof),
		.status            (res_out.status),
		.read_byte         (res_out.read_byte),
		.unassembled_count (res_out.unassembled_count),
		.readable_count    (res_out.readable_count),
		.input_ended       (res_out.input_ended)
	);

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for tcp_stream_reassembler: predicted results checked per transfer.
`timescale 1ns / 1ps

module tb_top;

	localparam int CAP = tsr_pkg::CAPACITY_DEF;

	typedef struct {
		logic req;
		logic [tsr_pkg::IDX_W-1:0] idx;
		logic [tsr_pkg::BYTE_W-1:0] data;
		logic has;
		logic first;
		logic last;
		logic eofb;
	} seg_item_t;

	typedef struct {
		logic [tsr_pkg::STAT_W-1:0] status;
		logic [tsr_pkg::BYTE_W-1:0] rbyte;
		logic [tsr_pkg::CNT_W-1:0] pending;
		logic [tsr_pkg::CNT_W-1:0] readable;
		logic ended;
	} stream_res_t;

	logic clk;
	logic arst_n;

	tsr_in_if seg_in ();
	tsr_out_if res_out ();

	tcp_stream_reassembler #(.CAPACITY(CAP)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.seg_in(seg_in.sink),
		.res_out(res_out.source)
	);

	logic [tsr_pkg::BYTE_W-1:0] ring_bytes [CAP];
	logic ring_marks [CAP];
	logic [31:0] rd_ptr;
	logic [31:0] asm_ptr;
	logic [31:0] pend_cnt;
	logic eof_flag;
	logic end_flag;
	logic seg_keep;
	logic [31:0] snap_rd;
	logic [31:0] snap_asm;

	stream_res_t expected_q [$];
	int err_cnt;
	int item_cnt;
	int res_cnt;
	int hold_cycles;
	bit smooth;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("tcp_stream_reassembler verification failed");
		$finish;
	end

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic advance_run();
		int guard;
		guard = 0;
		while (guard < CAP && asm_ptr != 32'hFFFF_FFFF) begin
			if (!ring_marks[asm_ptr % CAP])
				break;
			ring_marks[asm_ptr % CAP] = 1'b0;
			if (pend_cnt > 0)
				pend_cnt--;
			asm_ptr++;
			guard++;
		end
	endtask

	task automatic predict_stream(input seg_item_t it, output stream_res_t r);
		logic [32:0] win_end;
		logic beyond;
		int slot;
		r.rbyte = '0;
		if (it.req == tsr_pkg::REQ_READ) begin
			if (asm_ptr != rd_ptr) begin
				r.rbyte = ring_bytes[rd_ptr % CAP];
				rd_ptr++;
				r.status = tsr_pkg::ST_READ_OK;
			end else begin
				r.status = tsr_pkg::ST_EMPTY;
			end
		end else begin
			if (it.first) begin
				snap_rd = rd_ptr;
				snap_asm = asm_ptr;
				seg_keep = 1'b0;
			end
			win_end = {1'b0, snap_rd} + 33'(CAP);
			beyond = ({1'b0, it.idx} >= win_end) || (it.idx == 32'hFFFF_FFFF);
			if (!beyond && it.idx >= snap_asm)
				seg_keep = 1'b1;
			if (it.idx < asm_ptr) begin
				r.status = tsr_pkg::ST_DUP;
			end else if (beyond) begin
				r.status = tsr_pkg::ST_BEYOND;
			end else if (!it.has) begin
				r.status = tsr_pkg::ST_STORED;
			end else begin
				slot = it.idx % CAP;
				if (ring_marks[slot]) begin
					r.status = tsr_pkg::ST_DUP;
				end else begin
					ring_bytes[slot] = it.data;
					ring_marks[slot] = 1'b1;
					pend_cnt++;
					r.status = tsr_pkg::ST_STORED;
					if (it.idx == asm_ptr)
						advance_run();
				end
			end
			if (it.last && seg_keep) begin
				if (it.eofb)
					eof_flag = 1'b1;
				if (eof_flag && pend_cnt == 0)
					end_flag = 1'b1;
			end
		end
		r.pending = pend_cnt[tsr_pkg::CNT_W-1:0];
		r.readable = tsr_pkg::CNT_W'(asm_ptr - rd_ptr);
		r.ended = end_flag;
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			res_out.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (smooth) begin
			res_out.ready <= 1'b1;
		end else begin
			res_out.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		stream_res_t w;
		if (arst_n && res_out.valid && res_out.ready) begin
			res_cnt++;
			if (expected_q.size() == 0) begin
				report("unexpected result", res_out.status, -1);
			end else begin
				w = expected_q.pop_front();
				if (res_out.status !== w.status)
					report("status", res_out.status, w.status);
				if (res_out.read_byte !== w.rbyte)
					report("read_byte", res_out.read_byte, w.rbyte);
				if (res_out.unassembled_count !== w.pending)
					report("unassembled_count", res_out.unassembled_count, w.pending);
				if (res_out.readable_count !== w.readable)
					report("readable_count", res_out.readable_count, w.readable);
				if (res_out.input_ended !== w.ended)
					report("input_ended", res_out.input_ended, w.ended);
			end
		end
	end

	task automatic send_item(input seg_item_t it);
		stream_res_t r;
		if (!smooth && burst_left == 0) begin
			seg_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		seg_in.valid <= 1'b1;
		seg_in.req_type <= it.req;
		seg_in.byte_index <= it.idx;
		seg_in.data_byte <= it.data;
		seg_in.has_byte <= it.has;
		seg_in.seg_first <= it.first;
		seg_in.seg_last <= it.last;
		seg_in.eof <= it.eofb;
		do @(posedge clk); while (!seg_in.ready);
		predict_stream(it, r);
		expected_q.push_back(r);
		item_cnt++;
	endtask

	task automatic send_seg(input logic [31:0] start, input int len, input logic eofb);
		seg_item_t it;
		for (int i = 0; i < len; i++) begin
			it.req = tsr_pkg::REQ_SEG;
			it.idx = start + i;
			it.data = tsr_pkg::BYTE_W'($urandom);
			it.has = 1'b1;
			it.first = (i == 0);
			it.last = (i == len - 1);
			it.eofb = eofb;
			send_item(it);
		end
	endtask

	task automatic send_empty(input logic [31:0] idx, input logic eofb);
		seg_item_t it;
		it = '{tsr_pkg::REQ_SEG, idx, tsr_pkg::BYTE_W'($urandom), 1'b0, 1'b1, 1'b1, eofb};
		send_item(it);
	endtask

	task automatic send_reads(input int n);
		seg_item_t it;
		for (int i = 0; i < n; i++) begin
			it = '{tsr_pkg::REQ_READ, $urandom, tsr_pkg::BYTE_W'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 1'($urandom)};
			send_item(it);
		end
	endtask

	task automatic wait_idle();
		seg_in.valid <= 1'b0;
		burst_left = 0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		seg_item_t it;
		send_empty(32'd0, 1'b0);
		send_reads(1);
		send_seg(32'd2, 2, 1'b0);
		send_seg(32'd1, 1, 1'b0);
		send_seg(32'd1, 1, 1'b0);
		it = '{tsr_pkg::REQ_SEG, 32'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0};
		send_item(it);
		it = '{tsr_pkg::REQ_SEG, 32'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0};
		send_item(it);
		send_seg(32'd6, 1, 1'b0);
		send_seg(32'd6, 1, 1'b0);
		send_seg(32'd5000, 2, 1'b1);
		send_seg(32'hFFFF_FFFF, 1, 1'b1);
		send_empty(32'hFFFF_FFFF, 1'b0);
		send_empty(32'd9, 1'b0);
		send_empty(32'd1, 1'b0);
		it = '{tsr_pkg::REQ_SEG, 32'd8, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0};
		send_item(it);
		it = '{tsr_pkg::REQ_SEG, 32'd4, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b0};
		send_item(it);
		send_reads(6);
		send_seg(32'd3, 1, 1'b0);
		send_reads(3);
	endtask

	task automatic test_random_segments(input int n_items);
		int start_cnt;
		int off;
		seg_item_t it;
		start_cnt = item_cnt;
		while (item_cnt - start_cnt < n_items) begin
			smooth = ($urandom_range(0, 9) == 0);
			case ($urandom_range(0, 9))
				0: begin
					it = '{tsr_pkg::REQ_SEG, $urandom, tsr_pkg::BYTE_W'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom), 1'b0};
					send_item(it);
				end
				1: send_seg(rd_ptr + CAP - 2 + $urandom_range(0, 4), $urandom_range(1, 4),
					1'b0);
				2: send_empty(asm_ptr + $urandom_range(0, 20), 1'b0);
				default: begin
					off = $urandom_range(0, 48);
					send_seg((asm_ptr + off >= 8) ? asm_ptr + off - 8 : 0,
						$urandom_range(1, 8), 1'b0);
				end
			endcase
			send_reads($urandom_range(0, 9));
		end
		smooth = 1'b0;
	endtask

	task automatic test_fill_window();
		send_reads(asm_ptr - rd_ptr);
		for (int i = 0; i < 128; i += 16)
			send_seg(asm_ptr, 16, 1'b0);
		send_reads(130);
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_cycles = 400;
		for (int i = 0; i < 20; i++)
			send_seg(asm_ptr + $urandom_range(0, 3), 1, 1'b0);
		send_reads(10);
	endtask

	task automatic test_end_of_stream();
		logic [31:0] base;
		send_reads(asm_ptr - rd_ptr);
		base = asm_ptr;
		send_seg(base + CAP + 50, 2, 1'b1);
		send_seg(base + 5, 2, 1'b0);
		send_seg(base, 3, 1'b1);
		send_seg(base + 3, 2, 1'b0);
		send_reads(9);
		send_seg(base + 7, 2, 1'b0);
		send_empty(base, 1'b1);
		send_reads(3);
	endtask

	initial begin
		err_cnt = 0;
		item_cnt = 0;
		res_cnt = 0;
		hold_cycles = 0;
		smooth = 1'b0;
		burst_left = 0;
		for (int i = 0; i < CAP; i++) begin
			ring_marks[i] = 1'b0;
			ring_bytes[i] = '0;
		end
		rd_ptr = 0;
		asm_ptr = 0;
		pend_cnt = 0;
		eof_flag = 1'b0;
		end_flag = 1'b0;
		seg_keep = 1'b0;
		snap_rd = 0;
		snap_asm = 0;
		arst_n = 1'b0;
		seg_in.valid = 1'b0;
		seg_in.req_type = tsr_pkg::REQ_SEG;
		seg_in.byte_index = '0;
		seg_in.data_byte = '0;
		seg_in.has_byte = 1'b0;
		seg_in.seg_first = 1'b0;
		seg_in.seg_last = 1'b0;
		seg_in.eof = 1'b0;
		res_out.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_idle();
		test_random_segments(250);
		test_backpressure();
		test_fill_window();
		wait_idle();
		test_random_segments(250);
		test_end_of_stream();
		wait_idle();
		repeat (40) @(posedge clk);

		$display("Covered %0d transfers in, %0d results out: reordering, duplicates,", item_cnt,
			res_cnt);
		$display("window overflow, long contiguous run, long output stall and end of stream.");
		if (err_cnt == 0 && expected_q.size() == 0)
			$display("tcp_stream_reassembler verification clean");
		else
			$display("tcp_stream_reassembler verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tsr_pkg.sv
rtl/tsr_if.sv
rtl/tsr_ctrl.sv
rtl/tsr_dp.sv
rtl/tcp_stream_reassembler.sv
sim/tb_top.sv
